// ----- hdl/hvt_pkg.sv -----
package hvt_pkg;

  localparam int CoordW  = 16;
  localparam int CostW   = 24;
  localparam int IdW     = 10;
  localparam int StatusW = 2;
  localparam int NumCoord = 4;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StVtxFull  = 2'd1,
    StBktFull  = 2'd2,
    StNbrFull  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HASH,
    S_BIN,
    S_BKT_RD,
    S_BKT_WAIT,
    S_VC_RD,
    S_VC_WAIT,
    S_VC_CMP,
    S_DECIDE,
    S_EDGE_CHK,
    S_NA_RD,
    S_NA_WAIT,
    S_NA_CMP,
    S_NB_RD,
    S_NB_WAIT,
    S_NB_CMP,
    S_EDGE_A,
    S_EDGE_AW,
    S_EDGE_B,
    S_EDGE_BW,
    S_OUT,
    S_CLEAR
  } state_e;

  // one round of the integer mix, selected by step index
  function automatic logic [31:0] mix_step(input logic [31:0] k, input logic [2:0] s);
    logic [31:0] r;
    case (s)
      3'd0: r = k + (k << 12);
      3'd1: r = k ^ (k >> 22);
      3'd2: r = k + (k << 4);
      3'd3: r = k ^ (k >> 9);
      3'd4: r = k + (k << 10);
      3'd5: r = k ^ (k >> 2);
      3'd6: r = k + (k << 7);
      default: r = k ^ (k >> 12);
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/hvt_if.sv -----
interface hvt_in_if;
  import hvt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] coord_0;
  logic signed [CoordW-1:0] coord_1;
  logic signed [CoordW-1:0] coord_2;
  logic signed [CoordW-1:0] coord_3;
  logic [CostW-1:0]         edge_cost;
  logic                     path_start;
  modport source (output valid, coord_0, coord_1, coord_2, coord_3, edge_cost, path_start,
                  input ready);
  modport sink (input valid, coord_0, coord_1, coord_2, coord_3, edge_cost, path_start,
                output ready);
endinterface

interface hvt_out_if;
  import hvt_pkg::*;
  logic               valid;
  logic               ready;
  logic [IdW-1:0]     vertex_id;
  logic               is_new;
  logic [StatusW-1:0] status;
  modport source (output valid, vertex_id, is_new, status, input ready);
  modport sink (input valid, vertex_id, is_new, status, output ready);
endinterface

// ----- hdl/hvt_ram.sv -----
module hvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/hvt_hash.sv -----
// shared mix unit: one shift/add or shift/xor round per cycle
module hvt_hash
  import hvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] key_i,
  output logic        done_o,
  output logic [31:0] mix_o
);
  logic [31:0] k_q, k_d;
  logic [2:0]  s_q, s_d;
  logic        busy_q, busy_d;

  always_comb begin
    k_d = k_q;
    s_d = s_q;
    busy_d = busy_q;
    if (load_i) begin
      k_d = key_i;
      s_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      k_d = mix_step(k_q, s_q);
      s_d = s_q + 3'd1;
      if (s_q == 3'd7) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      s_q <= '0;
    end else begin
      busy_q <= busy_d;
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i) k_q <= k_d;

  assign done_o = !busy_q && !load_i;
  assign mix_o  = k_q;
endmodule

// ----- hdl/hashed_vertex_table_edge_insert.sv -----
// hashed vertex table with undirected edge insertion
//
// channels: in_if (sink) carries one path point per beat: four signed
// coordinates, an edge cost and a path-start flag; out_if (source) returns
// one beat per point: vertex id, new-vertex flag and a status code.
// cfg_we_i/cfg_wdata_i write num_dims; write only while idle (not enforced by the block).
//
// one point at a time: in_ready is high only in idle. a point goes through a
// load, eight mix rounds and a sum per dimension, a further hashing pass for
// the bin, a read of each bucket entry (stopping at a match), a read of each
// adjacency entry on each endpoint and the edge update. the result beat goes
// valid as in_ready returns.
//
// after reset a clearing pass zeroes the bucket and neighbor fill counts, one
// entry a cycle over max(HASH_BINS, MAX_VERTICES) entries (1024 by default),
// with in_ready low; other ram contents are only read below the fill counts.
// num_dims resets to 4. the result beat sits in an output register; while the
// receiver stalls the block takes one more point and holds it in its last step.
module hashed_vertex_table_edge_insert
  import hvt_pkg::*;
#(
  parameter int HASH_BINS     = 1024,
  parameter int BUCKET_DEPTH  = 4,
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_NEIGHBORS = 8,
  parameter int MAX_DIMS      = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hvt_in_if.sink     in_if,
  hvt_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);
  localparam int BinW  = $clog2(HASH_BINS);
  localparam int BfW   = $clog2(BUCKET_DEPTH + 1);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int VcW   = $clog2(MAX_VERTICES + 1);
  localparam int NfW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int BaW   = $clog2(HASH_BINS * BUCKET_DEPTH);
  localparam int NaW   = $clog2(MAX_VERTICES * MAX_NEIGHBORS);
  localparam int DimLim = (MAX_DIMS < NumCoord) ? MAX_DIMS : NumCoord;
  localparam int ClrN  = (HASH_BINS > MAX_VERTICES) ? HASH_BINS : MAX_VERTICES;
  localparam int ClrW  = $clog2(ClrN);

  state_e st_q, st_d;

  // configuration
  logic [2:0] nd_cfg_q;
  logic [2:0] nd_eff;
  always_comb begin
    nd_eff = (nd_cfg_q == 3'd0) ? 3'd1 : nd_cfg_q;
    if (nd_eff > 3'(DimLim)) nd_eff = 3'(DimLim);
  end

  // captured item
  logic [CoordW-1:0] crd_q [NumCoord];
  logic [CostW-1:0]  cost_q;
  logic              start_q;

  // control state
  logic [VcW-1:0]   vcount_q, vcount_d;
  logic [VW-1:0]    prev_q, prev_d;
  logic             pvalid_q, pvalid_d;
  logic [ClrW-1:0]  clr_q, clr_d;

  // work registers
  logic [1:0]       dim_q, dim_d;
  logic [31:0]      h_q, h_d;
  logic [BinW-1:0]  bin_q, bin_d;
  logic [BfW-1:0]   idx_q, idx_d;
  logic [VW-1:0]    cand_q, cand_d;
  logic [VW-1:0]    id_q, id_d;
  logic             isnew_q, isnew_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic             found_q, found_d;
  logic [NfW-1:0]   pa_q, pa_d, pb_q, pb_d;
  logic             ovalid_q, ovalid_d;

  // hash unit
  logic        h_load, h_done;
  logic [31:0] h_key, h_mix;
  logic        hash_fin_q, hash_fin_d;

  hvt_hash u_hash (
    .clk_i, .rst_ni, .load_i(h_load), .key_i(h_key), .done_o(h_done), .mix_o(h_mix)
  );

  // rams
  logic            bk_we;
  logic [BaW-1:0]  bk_wa, bk_ra;
  logic [VW-1:0]   bk_wd, bk_rd;
  logic            vc_we;
  logic [VW-1:0]   vc_wa, vc_ra;
  logic [63:0]     vc_wd, vc_rd;
  logic            ni_we;
  logic [NaW-1:0]  ni_wa, ni_ra;
  logic [VW-1:0]   ni_wd, ni_rd;
  logic            nc_we;
  logic [CostW-1:0] nc_wd, nc_rd;

  // fill counts: bucket fill read at the next bin, neighbor fill kept twice
  // so both endpoints read at once
  logic            bf_we;
  logic [BinW-1:0] bf_wa;
  logic [BfW-1:0]  bf_wd, bf_cur;
  logic            nf_we;
  logic [VW-1:0]   nf_wa;
  logic [NfW-1:0]  nf_wd, nf_a, nf_b;

  hvt_ram #(.Width(VW), .Depth(HASH_BINS * BUCKET_DEPTH)) u_bkt (
    .clk_i, .we_i(bk_we), .waddr_i(bk_wa), .wdata_i(bk_wd), .raddr_i(bk_ra), .rdata_o(bk_rd));
  hvt_ram #(.Width(64), .Depth(MAX_VERTICES)) u_vcrd (
    .clk_i, .we_i(vc_we), .waddr_i(vc_wa), .wdata_i(vc_wd), .raddr_i(vc_ra), .rdata_o(vc_rd));
  hvt_ram #(.Width(VW), .Depth(MAX_VERTICES * MAX_NEIGHBORS)) u_nid (
    .clk_i, .we_i(ni_we), .waddr_i(ni_wa), .wdata_i(ni_wd), .raddr_i(ni_ra), .rdata_o(ni_rd));
  hvt_ram #(.Width(CostW), .Depth(MAX_VERTICES * MAX_NEIGHBORS)) u_ncost (
    .clk_i, .we_i(nc_we), .waddr_i(ni_wa), .wdata_i(nc_wd), .raddr_i(ni_ra), .rdata_o(nc_rd));
  hvt_ram #(.Width(BfW), .Depth(HASH_BINS)) u_bfill (
    .clk_i, .we_i(bf_we), .waddr_i(bf_wa), .wdata_i(bf_wd), .raddr_i(bin_d), .rdata_o(bf_cur));
  hvt_ram #(.Width(NfW), .Depth(MAX_VERTICES)) u_nfill_a (
    .clk_i, .we_i(nf_we), .waddr_i(nf_wa), .wdata_i(nf_wd), .raddr_i(prev_q), .rdata_o(nf_a));
  hvt_ram #(.Width(NfW), .Depth(MAX_VERTICES)) u_nfill_b (
    .clk_i, .we_i(nf_we), .waddr_i(nf_wa), .wdata_i(nf_wd), .raddr_i(id_d), .rdata_o(nf_b));

  logic [63:0] packed_c;
  assign packed_c = {crd_q[3], crd_q[2], crd_q[1], crd_q[0]};

  // coordinate match over the active dimensions
  logic coord_eq;
  always_comb begin
    coord_eq = 1'b1;
    for (int d = 0; d < NumCoord; d++) begin
      if (d < int'(nd_eff) && vc_rd[16*d +: 16] != packed_c[16*d +: 16]) coord_eq = 1'b0;
    end
  end

  logic a_full, b_full;
  assign a_full = (pa_q == NfW'(MAX_NEIGHBORS)) && (nf_a >= NfW'(MAX_NEIGHBORS));
  assign b_full = (pb_q == NfW'(MAX_NEIGHBORS)) && (nf_b >= NfW'(MAX_NEIGHBORS));

  logic [31:0] key_ext;
  assign key_ext = {{16{crd_q[dim_q][15]}}, crd_q[dim_q]};

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLEAR:    if (clr_q == ClrW'(ClrN - 1)) st_d = S_IDLE;
      S_IDLE:     if (in_if.valid) st_d = S_HASH;
      S_HASH:     if (hash_fin_q && h_done && dim_q == 2'(nd_eff - 3'd1)) st_d = S_BIN;
      S_BIN:      if (hash_fin_q && h_done) st_d = S_BKT_RD;
      S_BKT_RD:   st_d = (idx_q < bf_cur && idx_q < BfW'(BUCKET_DEPTH)) ? S_BKT_WAIT : S_DECIDE;
      S_BKT_WAIT: st_d = S_VC_RD;
      S_VC_RD:    st_d = S_VC_WAIT;
      S_VC_WAIT:  st_d = S_VC_CMP;
      S_VC_CMP:   st_d = coord_eq ? S_DECIDE : S_BKT_RD;
      S_DECIDE:   st_d = S_EDGE_CHK;
      S_EDGE_CHK: st_d = (stat_q == StOk && !start_q && pvalid_q) ? S_NA_RD : S_OUT;
      S_NA_RD:    st_d = (pa_q < nf_a && pa_q < NfW'(MAX_NEIGHBORS)) ? S_NA_WAIT : S_NB_RD;
      S_NA_WAIT:  st_d = S_NA_CMP;
      S_NA_CMP:   st_d = (ni_rd == id_q) ? S_NB_RD : S_NA_RD;
      S_NB_RD:    st_d = (pb_q < nf_b && pb_q < NfW'(MAX_NEIGHBORS)) ? S_NB_WAIT : S_EDGE_A;
      S_NB_WAIT:  st_d = S_NB_CMP;
      S_NB_CMP:   st_d = (ni_rd == prev_q) ? S_EDGE_A : S_NB_RD;
      S_EDGE_A:   st_d = (a_full || b_full) ? S_OUT : S_EDGE_AW;
      S_EDGE_AW:  st_d = (prev_q != id_q) ? S_EDGE_B : S_OUT;
      S_EDGE_B:   st_d = S_EDGE_BW;
      S_EDGE_BW:  st_d = S_OUT;
      S_OUT:      if (!ovalid_q || out_if.ready) st_d = S_IDLE;
      default:    st_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    vcount_d = vcount_q; prev_d = prev_q; pvalid_d = pvalid_q; clr_d = clr_q;
    dim_d = dim_q; h_d = h_q; bin_d = bin_q; idx_d = idx_q; cand_d = cand_q;
    id_d = id_q; isnew_d = isnew_q; stat_d = stat_q; found_d = found_q;
    pa_d = pa_q; pb_d = pb_q; hash_fin_d = hash_fin_q;
    ovalid_d = ovalid_q;
    h_load = 1'b0; h_key = key_ext;
    bk_we = 1'b0; bk_wa = BaW'(bin_q) * BaW'(BUCKET_DEPTH) + BaW'(bf_cur);
    bk_wd = vcount_q[VW-1:0];
    bk_ra = BaW'(bin_q) * BaW'(BUCKET_DEPTH) + BaW'(idx_q);
    vc_we = 1'b0; vc_wa = vcount_q[VW-1:0]; vc_wd = packed_c; vc_ra = cand_q;
    ni_we = 1'b0; nc_we = 1'b0;
    ni_wa = NaW'(prev_q) * NaW'(MAX_NEIGHBORS) + NaW'(pa_q);
    ni_wd = id_q; nc_wd = cost_q;
    ni_ra = NaW'(prev_q) * NaW'(MAX_NEIGHBORS) + NaW'(pa_q);
    bf_we = 1'b0; bf_wa = bin_q; bf_wd = bf_cur + BfW'(1);
    nf_we = 1'b0; nf_wa = prev_q; nf_wd = nf_a + NfW'(1);
    if (out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        bf_we = 1'b1; bf_wa = clr_q[BinW-1:0]; bf_wd = '0;
        nf_we = 1'b1; nf_wa = clr_q[VW-1:0]; nf_wd = '0;
        clr_d = clr_q + ClrW'(1);
      end
      S_IDLE: begin
        dim_d = '0; h_d = '0; hash_fin_d = 1'b0;
      end
      S_HASH: begin
        if (!hash_fin_q) begin
          h_load = 1'b1; hash_fin_d = 1'b1;
        end else if (h_done) begin
          h_d = h_q + (h_mix << dim_q);
          hash_fin_d = 1'b0;
          if (dim_q != 2'(nd_eff - 3'd1)) dim_d = dim_q + 2'd1;
        end
      end
      S_BIN: begin
        h_key = h_q;
        if (!hash_fin_q) begin
          h_load = 1'b1; hash_fin_d = 1'b1;
        end else if (h_done) begin
          bin_d = h_mix[BinW-1:0];
          idx_d = '0; found_d = 1'b0; id_d = '0; isnew_d = 1'b0; stat_d = StOk;
        end
      end
      S_BKT_WAIT: ;
      S_VC_RD: begin
        cand_d = bk_rd;
        idx_d = idx_q + BfW'(1);
      end
      S_VC_CMP: begin
        if (coord_eq) begin
          found_d = 1'b1; id_d = cand_q;
        end
      end
      S_DECIDE: begin
        if (!found_q) begin
          if (vcount_q >= VcW'(MAX_VERTICES)) stat_d = StVtxFull;
          else if (bf_cur >= BfW'(BUCKET_DEPTH)) stat_d = StBktFull;
          else begin
            id_d = vcount_q[VW-1:0];
            vcount_d = vcount_q + VcW'(1);
            vc_we = 1'b1; bk_we = 1'b1; bf_we = 1'b1; isnew_d = 1'b1;
          end
        end
        pa_d = '0; pb_d = '0;
      end
      S_NA_RD: begin
        if (!(pa_q < nf_a && pa_q < NfW'(MAX_NEIGHBORS))) pa_d = NfW'(MAX_NEIGHBORS);
      end
      S_NA_CMP: if (ni_rd != id_q) pa_d = pa_q + NfW'(1);
      S_NB_RD: begin
        ni_ra = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
        if (!(pb_q < nf_b && pb_q < NfW'(MAX_NEIGHBORS))) pb_d = NfW'(MAX_NEIGHBORS);
      end
      S_NB_WAIT: ni_ra = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
      S_NB_CMP: begin
        ni_ra = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
        if (ni_rd != prev_q) pb_d = pb_q + NfW'(1);
      end
      S_EDGE_A: begin
        // read existing cost of the a-side entry
        if (a_full || b_full) stat_d = StNbrFull;
      end
      S_EDGE_AW: begin
        if (pa_q == NfW'(MAX_NEIGHBORS)) begin
          ni_wa = NaW'(prev_q) * NaW'(MAX_NEIGHBORS) + NaW'(nf_a);
          ni_we = 1'b1; nc_we = 1'b1; nf_we = 1'b1;
        end else if (cost_q < nc_rd) nc_we = 1'b1;
      end
      S_EDGE_B: ni_ra = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
      S_EDGE_BW: begin
        ni_ra = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
        ni_wd = prev_q;
        ni_wa = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(pb_q);
        nf_wa = id_q; nf_wd = nf_b + NfW'(1);
        if (pb_q == NfW'(MAX_NEIGHBORS)) begin
          ni_wa = NaW'(id_q) * NaW'(MAX_NEIGHBORS) + NaW'(nf_b);
          ni_we = 1'b1; nc_we = 1'b1; nf_we = 1'b1;
        end else if (cost_q < nc_rd) nc_we = 1'b1;
      end
      S_OUT: begin
        if (!ovalid_q || out_if.ready) begin
          ovalid_d = 1'b1;
          if (stat_q == StVtxFull || stat_q == StBktFull) begin
            pvalid_d = 1'b0;
          end else begin
            pvalid_d = 1'b1; prev_d = id_q;
          end
        end
      end
      default: ;
    endcase
  end

  logic [IdW-1:0]     oid_q;
  logic               onew_q;
  logic [StatusW-1:0] ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      nd_cfg_q <= 3'd4;
      vcount_q <= '0; prev_q <= '0; pvalid_q <= 1'b0; clr_q <= '0;
      hash_fin_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) nd_cfg_q <= cfg_wdata_i;
      vcount_q <= vcount_d; prev_q <= prev_d; pvalid_q <= pvalid_d; clr_q <= clr_d;
      hash_fin_q <= hash_fin_d; ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dim_q <= dim_d; h_q <= h_d; bin_q <= bin_d; idx_q <= idx_d; cand_q <= cand_d;
    id_q <= id_d; isnew_q <= isnew_d; stat_q <= stat_d; found_q <= found_d;
    pa_q <= pa_d; pb_q <= pb_d;
    if (st_q == S_IDLE && in_if.valid) begin
      crd_q[0] <= in_if.coord_0; crd_q[1] <= in_if.coord_1;
      crd_q[2] <= in_if.coord_2; crd_q[3] <= in_if.coord_3;
      cost_q <= in_if.edge_cost; start_q <= in_if.path_start;
    end
    if (st_q == S_OUT && (!ovalid_q || out_if.ready)) begin
      if (stat_q == StVtxFull || stat_q == StBktFull) begin
        oid_q <= '0; onew_q <= 1'b0;
      end else begin
        oid_q <= IdW'(id_q); onew_q <= isnew_q;
      end
      ost_q <= stat_q;
    end
  end

  assign in_if.ready      = (st_q == S_IDLE);
  assign out_if.valid     = ovalid_q;
  assign out_if.vertex_id = oid_q;
  assign out_if.is_new    = onew_q;
  assign out_if.status    = ost_q;
endmodule
